@@ rtl/smrs_pkg.sv @@
// Shared types and constants for the six-register machine step core.
// Holds the opcode set, field widths, CSR indexes and the commit control struct.
// No dependencies; every other file of the block takes names from here.
`timescale 1ns / 1ps
`default_nettype none

package smrs_pkg;

   // Fixed widths of the channel and CSR fields.
   localparam int FieldWidth   = 32;
   localparam int OpWidth      = 4;
   localparam int DestWidth    = 3;
   localparam int PtrSelWidth  = 3;
   localparam int ProgLenWidth = 11;
   localparam int CsrDataWidth = 11;
   localparam int CsrIdxWidth  = 1;

   localparam logic [ProgLenWidth-1:0] ProgLenReset = 11'd1024;
   localparam logic [PtrSelWidth-1:0]  PtrSelReset  = 3'd0;

   // Instruction set: register (r) and immediate (i) forms.
   typedef enum logic [OpWidth-1:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } op_code_type;

   // Configuration register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_POINTER_REGISTER = 1'b0,
      CSR_PROGRAM_LENGTH   = 1'b1
   } csr_index_type;

   // Write-back control handed from the execute stage to the register file.
   typedef struct packed {
      logic                   fire;
      logic                   write_dest;
      logic [DestWidth-1:0]   dest;
      logic [PtrSelWidth-1:0] ptr_sel;
   } commit_type;

   // True when the opcode reads operand A as a register index.
   function automatic logic op_reads_a(input op_code_type op);
      logic reads;
      case (op) inside
         OP_SETI, OP_GTIR, OP_EQIR: reads = 1'b0;
         default:                   reads = 1'b1;
      endcase
      return reads;
   endfunction

   // True when the opcode reads operand B as a register index.
   function automatic logic op_reads_b(input op_code_type op);
      logic reads;
      case (op) inside
         OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR,
         OP_EQRR: reads = 1'b1;
         default: reads = 1'b0;
      endcase
      return reads;
   endfunction

endpackage

`default_nettype wire

@@ rtl/smrs_ifs.sv @@
// Channel interfaces of the six-register machine step core.
// smrs_req_if carries instruction beats, smrs_rsp_if carries result beats.
// Depends on smrs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface smrs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [smrs_pkg::OpWidth-1:0]         op_code;
   logic signed [smrs_pkg::FieldWidth-1:0] operand_a;
   logic signed [smrs_pkg::FieldWidth-1:0] operand_b;
   logic [smrs_pkg::DestWidth-1:0]       dest_index;

   modport source (output valid, output op_code, output operand_a, output operand_b,
                   output dest_index, input ready);
   modport sink   (input valid, input op_code, input operand_a, input operand_b,
                   input dest_index, output ready);
endinterface

interface smrs_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [smrs_pkg::FieldWidth-1:0] next_pointer;
   logic signed [smrs_pkg::FieldWidth-1:0] written_value;
   logic                                   halted;
   logic                                   bad_index;

   modport source (output valid, output next_pointer, output written_value,
                   output halted, output bad_index, input ready);
   modport sink   (input valid, input next_pointer, input written_value,
                   input halted, input bad_index, output ready);
endinterface

`default_nettype wire

@@ rtl/six_register_machine_step_core.sv @@
// Top level of the six-register machine step core: input register, execute
// logic, register file and result register. Depends on smrs_pkg, smrs_ifs,
// smrs_alu and smrs_regfile.
//
//   Channel  Role    Beat contents
//   req_bus  sink    op_code, operand_a, operand_b, dest_index
//   rsp_bus  source  next_pointer, written_value, halted, bad_index
//   csr_*    write   csr_index selects pointer_register or program_length
//
// One instruction per cycle while rsp_bus is not stalled; a request beat passes
// the input register and then the result register. The rate is set by the
// register file write-back loop, which executes and commits each registered instruction.
// Reset clears the register file and loads the CSR reset values.
// A stalled result holds the execute stage; the input register still takes
// a beat whenever the execute stage can move on in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module six_register_machine_step_core #(
   parameter int NUM_REGS   = 6,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   smrs_req_if.sink                                  req_bus,
   smrs_rsp_if.source                                rsp_bus,
   input  wire logic                                 csr_write_en,
   input  wire logic [smrs_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [smrs_pkg::CsrDataWidth-1:0]    csr_wdata
);

   localparam int RegIdxW = $clog2(NUM_REGS);
   localparam int FW      = smrs_pkg::FieldWidth;
   localparam int CmpW    = (DATA_WIDTH > smrs_pkg::ProgLenWidth)
                            ? DATA_WIDTH : smrs_pkg::ProgLenWidth;
   localparam logic [FW-1:0] NumRegsW = FW'(NUM_REGS);

   // Configuration registers.
   logic [smrs_pkg::PtrSelWidth-1:0]  ptr_sel_ff;
   logic [smrs_pkg::ProgLenWidth-1:0] prog_len_ff;

   // Input register stage.
   logic                           s1_valid_ff, s1_valid_in;
   smrs_pkg::op_code_type          s1_op_ff;
   logic [FW-1:0]                  s1_a_ff;
   logic [FW-1:0]                  s1_b_ff;
   logic [smrs_pkg::DestWidth-1:0] s1_dest_ff;

   // Result register stage.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]        next_pointer_ff;
   logic [FW-1:0]        written_value_ff;
   logic                 halted_ff;
   logic                 bad_index_ff;

   // Execute stage signals.
   logic                  req_accept;
   logic                  advance;
   logic                  fire;
   logic                  a_ok, b_ok, dest_ok, ptr_ok;
   logic                  bad;
   logic [RegIdxW-1:0]    rd_a_idx, rd_b_idx;
   logic [DATA_WIDTH-1:0] rd_a_data, rd_b_data;
   logic [DATA_WIDTH-1:0] reg_a, reg_b, imm_a, imm_b;
   logic [DATA_WIDTH-1:0] alu_result;
   logic [DATA_WIDTH-1:0] wr_value;
   logic [DATA_WIDTH-1:0] next_ptr;
   logic [FW+DATA_WIDTH-1:0] a_sext, b_sext;
   logic                  halt_now;
   smrs_pkg::commit_type  commit;

   // Handshake: the execute stage moves when the result register is free.
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && advance;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_sel_ff  <= smrs_pkg::PtrSelReset;
         prog_len_ff <= smrs_pkg::ProgLenReset;
      end else if (csr_write_en) begin
         unique case (smrs_pkg::csr_index_type'(csr_index))
            smrs_pkg::CSR_POINTER_REGISTER:
               ptr_sel_ff <= csr_wdata[smrs_pkg::PtrSelWidth-1:0];
            smrs_pkg::CSR_PROGRAM_LENGTH:
               prog_len_ff <= csr_wdata[smrs_pkg::ProgLenWidth-1:0];
            default: ;
         endcase
      end
   end

   // Input register; the payload needs no reset.
   assign s1_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= smrs_pkg::op_code_type'(req_bus.op_code);
         s1_a_ff    <= req_bus.operand_a;
         s1_b_ff    <= req_bus.operand_b;
         s1_dest_ff <= req_bus.dest_index;
      end
   end

   // Index checks; an operand used as an immediate is never checked.
   assign a_ok    = s1_a_ff < NumRegsW;
   assign b_ok    = s1_b_ff < NumRegsW;
   assign dest_ok = FW'(s1_dest_ff) < NumRegsW;
   assign ptr_ok  = FW'(ptr_sel_ff) < NumRegsW;
   assign bad     = (smrs_pkg::op_reads_a(s1_op_ff) && !a_ok)
                 || (smrs_pkg::op_reads_b(s1_op_ff) && !b_ok)
                 || !dest_ok;

   assign rd_a_idx = a_ok ? s1_a_ff[RegIdxW-1:0] : '0;
   assign rd_b_idx = b_ok ? s1_b_ff[RegIdxW-1:0] : '0;
   assign reg_a    = a_ok ? rd_a_data : '0;
   assign reg_b    = b_ok ? rd_b_data : '0;

   // Immediates are sign-extended from the field width, then cut to the data width.
   assign a_sext = {{DATA_WIDTH{s1_a_ff[FW-1]}}, s1_a_ff};
   assign b_sext = {{DATA_WIDTH{s1_b_ff[FW-1]}}, s1_b_ff};
   assign imm_a  = a_sext[DATA_WIDTH-1:0];
   assign imm_b  = b_sext[DATA_WIDTH-1:0];

   smrs_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .op     (s1_op_ff),
      .reg_a  (reg_a),
      .reg_b  (reg_b),
      .imm_a  (imm_a),
      .imm_b  (imm_b),
      .result (alu_result)
   );

   assign wr_value = bad ? '0 : alu_result;

   // A bad pointer select commits nothing at all.
   assign commit.fire       = fire && ptr_ok;
   assign commit.write_dest = !bad;
   assign commit.dest       = s1_dest_ff;
   assign commit.ptr_sel    = ptr_sel_ff;

   smrs_regfile #(
      .NUM_REGS   (NUM_REGS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_a_idx  (rd_a_idx),
      .rd_b_idx  (rd_b_idx),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .commit    (commit),
      .wr_value  (wr_value),
      .next_ptr  (next_ptr)
   );

   // Halt when the new pointer is negative or past the program.
   assign halt_now = next_ptr[DATA_WIDTH-1]
                  || (CmpW'(next_ptr) >= CmpW'(prog_len_ff));

   // Result register.
   assign rsp_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (ptr_ok) begin
            next_pointer_ff  <= FW'(next_ptr);
            written_value_ff <= FW'(wr_value);
            halted_ff        <= halt_now;
            bad_index_ff     <= bad;
         end else begin
            next_pointer_ff  <= '0;
            written_value_ff <= '0;
            halted_ff        <= 1'b1;
            bad_index_ff     <= 1'b1;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.next_pointer  = next_pointer_ff;
   assign rsp_bus.written_value = written_value_ff;
   assign rsp_bus.halted        = halted_ff;
   assign rsp_bus.bad_index     = bad_index_ff;

endmodule

`default_nettype wire

@@ rtl/smrs_alu.sv @@
// Operation unit of the six-register machine: one instruction's value.
// Purely combinational; depends on smrs_pkg for the opcode type.
`timescale 1ns / 1ps
`default_nettype none

module smrs_alu #(
   parameter int DATA_WIDTH = 32
) (
   input  wire smrs_pkg::op_code_type op,
   input  wire logic [DATA_WIDTH-1:0] reg_a,
   input  wire logic [DATA_WIDTH-1:0] reg_b,
   input  wire logic [DATA_WIDTH-1:0] imm_a,
   input  wire logic [DATA_WIDTH-1:0] imm_b,
   output logic      [DATA_WIDTH-1:0] result
);

   logic [DATA_WIDTH-1:0] src_b;
   logic [DATA_WIDTH-1:0] product;
   logic [DATA_WIDTH-1:0] one;

   // Register forms take B from the file, immediate forms from the operand.
   always_comb begin
      case (op) inside
         smrs_pkg::OP_ADDR, smrs_pkg::OP_MULR, smrs_pkg::OP_BANR,
         smrs_pkg::OP_BORR: src_b = reg_b;
         default:           src_b = imm_b;
      endcase
   end

   // One shared multiplier; only the low word is kept (wrapping product).
   assign product = reg_a * src_b;
   assign one     = DATA_WIDTH'(1);

   // Result select; comparisons are signed at the data width.
   always_comb begin
      case (op)
         smrs_pkg::OP_ADDR, smrs_pkg::OP_ADDI: result = reg_a + src_b;
         smrs_pkg::OP_MULR, smrs_pkg::OP_MULI: result = product;
         smrs_pkg::OP_BANR, smrs_pkg::OP_BANI: result = reg_a & src_b;
         smrs_pkg::OP_BORR, smrs_pkg::OP_BORI: result = reg_a | src_b;
         smrs_pkg::OP_SETR: result = reg_a;
         smrs_pkg::OP_SETI: result = imm_a;
         smrs_pkg::OP_GTIR: result = ($signed(imm_a) > $signed(reg_b)) ? one : '0;
         smrs_pkg::OP_GTRI: result = ($signed(reg_a) > $signed(imm_b)) ? one : '0;
         smrs_pkg::OP_GTRR: result = ($signed(reg_a) > $signed(reg_b)) ? one : '0;
         smrs_pkg::OP_EQIR: result = (imm_a == reg_b) ? one : '0;
         smrs_pkg::OP_EQRI: result = (reg_a == imm_b) ? one : '0;
         smrs_pkg::OP_EQRR: result = (reg_a == reg_b) ? one : '0;
         default:           result = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/smrs_regfile.sv @@
// Register file of the six-register machine with its write-back logic.
// Two read ports, with the destination write and pointer increment in the same cycle.
// Depends on smrs_pkg for the commit control struct.
`timescale 1ns / 1ps
`default_nettype none

module smrs_regfile #(
   parameter int NUM_REGS   = 6,
   parameter int DATA_WIDTH = 32,
   localparam int RegIdxW   = $clog2(NUM_REGS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [RegIdxW-1:0]     rd_a_idx,
   input  wire logic [RegIdxW-1:0]     rd_b_idx,
   output logic      [DATA_WIDTH-1:0]  rd_a_data,
   output logic      [DATA_WIDTH-1:0]  rd_b_data,
   input  wire smrs_pkg::commit_type   commit,
   input  wire logic [DATA_WIDTH-1:0]  wr_value,
   output logic      [DATA_WIDTH-1:0]  next_ptr
);

   logic [DATA_WIDTH-1:0] regs_ff [NUM_REGS];
   logic [DATA_WIDTH-1:0] regs_in [NUM_REGS];
   logic [RegIdxW-1:0]    ptr_idx;
   logic [RegIdxW-1:0]    dest_idx;
   logic [DATA_WIDTH-1:0] ptr_base;

   assign rd_a_data = regs_ff[rd_a_idx];
   assign rd_b_data = regs_ff[rd_b_idx];

   // Both indexes are known to be in range whenever they are used.
   assign ptr_idx  = RegIdxW'(commit.ptr_sel);
   assign dest_idx = RegIdxW'(commit.dest);

   // The pointer sees the destination write of the same instruction first.
   assign ptr_base = (commit.write_dest && (commit.dest == commit.ptr_sel))
                     ? wr_value : regs_ff[ptr_idx];
   assign next_ptr = ptr_base + DATA_WIDTH'(1);

   // Write-back: pointer increment wins over the destination write.
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
         if (commit.fire) begin
            if (RegIdxW'(i) == ptr_idx) begin
               regs_in[i] = next_ptr;
            end else if (commit.write_dest && (RegIdxW'(i) == dest_idx)) begin
               regs_in[i] = wr_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (reset) begin
            regs_ff[i] <= '0;
         end else begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

endmodule

`default_nettype wire
